// ----- design/edc_pkg.sv -----
package edc_pkg;

  localparam int PointCount = 4096;
  localparam int IdxW = 12;
  localparam int AddrW = $clog2(PointCount);
  localparam int CoordW = 24;
  localparam int DiffW = 25;
  localparam int SqW = 50;
  localparam int LenW = 26;
  localparam int RootW = 25;
  localparam int QueueDepth = 2;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_EVAL  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_ROOT,
    BK_DIV
  } back_state_t;

  // One classified edge item handed from the front part to the back part.
  typedef struct packed {
    logic [AddrW-1:0] addr_a;
    logic [AddrW-1:0] addr_b;
    logic             out_a;
    logic             out_b;
    logic [23:0]      rest;
  } edge_item_t;

  typedef struct packed {
    logic push;
    logic full;
  } queue_ctl_t;

endpackage

// ----- design/edc_ram.sv -----
module edc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/edc_front.sv -----
module edc_front import edc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              action,
  input  logic [IdxW-1:0]   point_index,
  input  logic [IdxW-1:0]   first_index,
  input  logic [IdxW-1:0]   second_index,
  input  logic [23:0]       rest_length,
  input  logic              pop,
  input  logic              fetching,
  output logic              busy,
  output logic              wr_en,
  output logic [AddrW-1:0]  wr_addr,
  output logic              q_valid,
  output edge_item_t        q_head
);

  edge_item_t       slots [QueueDepth];
  logic             rd_ptr;
  logic             wr_ptr;
  logic [1:0]       count;
  logic             accept;
  queue_ctl_t       ctl;
  edge_item_t       item;

  // The queue holds classified edges until the back part takes them.
  // A write waits while an edge still has to read its endpoints.
  assign ctl.full = (count == 2'(QueueDepth));
  assign busy = ctl.full
                || ((action_t'(action) == ACT_WRITE) && (q_valid || fetching));
  assign accept = start && !busy;
  assign ctl.push = accept && (action_t'(action) == ACT_EVAL);

  // Writes go to the store at once; out-of-range writes are dropped.
  assign wr_en = accept && (action_t'(action) == ACT_WRITE)
                 && ({8'd0, point_index} < 20'(PointCount));
  assign wr_addr = AddrW'(point_index);

  always_comb begin
    item.addr_a = AddrW'(first_index);
    item.addr_b = AddrW'(second_index);
    item.out_a = !({8'd0, first_index} < 20'(PointCount));
    item.out_b = !({8'd0, second_index} < 20'(PointCount));
    item.rest = rest_length;
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      slots[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (ctl.push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(ctl.push) - 2'(pop);
    end
  end

  assign q_valid = (count != 2'd0);
  assign q_head = slots[rd_ptr];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ctl.full |-> !ctl.push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (ctl.push && !pop) |=> count == $past(count) + 2'd1) else $error("count");

endmodule

// ----- design/edc_back.sv -----
module edc_back import edc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  edge_item_t        q_head,
  input  logic [71:0]       rd_data,
  output logic              pop,
  output logic              fetching,
  output logic [AddrW-1:0]  rd_addr,
  output logic              strobe,
  output logic [25:0]       constraint_value,
  output logic [15:0]       grad_x,
  output logic [15:0]       grad_y,
  output logic [15:0]       grad_z,
  output logic              degenerate
);

  back_state_t      state;
  back_state_t      state_next;
  edge_item_t       cur;
  logic [1:0]       phase;
  logic [71:0]      pa;
  logic [DiffW-1:0] d [3];
  logic [DiffW-2:0] mag [3];
  logic [SqW-1:0]   sq;
  logic [SqW-1:0]   rem;
  logic [RootW-1:0] root;
  logic [4:0]       rstep;
  logic [LenW-1:0]  len;
  logic [40:0]      num;
  logic [LenW+1:0]  dvr;
  logic [16:0]      quo;
  logic [40:0]      drem;
  logic [4:0]       dstep;
  logic [1:0]       axis;
  logic [15:0]      g [3];
  logic             started;

  // Reading: phase 0 issues A, phase 1 issues B and latches A, phase 3 uses B.
  assign rd_addr = (phase == 2'd0) ? cur.addr_a : cur.addr_b;
  assign pop = (state == BK_IDLE) && q_valid;
  assign fetching = (state == BK_READ);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (q_valid) state_next = BK_READ;
      BK_READ: if (phase == 2'd3) state_next = BK_ROOT;
      BK_ROOT: if (rstep == 5'd25) state_next = (sq == '0) ? BK_IDLE : BK_DIV;
      BK_DIV:  if (axis == 2'd2 && dstep == 5'd17) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequential square root, one result bit per cycle.
  logic [SqW-1:0] trial;
  logic [SqW-1:0] rem_sh;
  assign rem_sh = {rem[SqW-3:0], sq[SqW-1-2*rstep[4:0] -: 2]};
  assign trial = {rem_sh[SqW-1:0]} - {{(SqW-RootW-2){1'b0}}, root, 2'b01};

  // Restoring division for one gradient axis, one quotient bit per cycle.
  // The partial remainder starts from the upper bits of the numerator.
  logic [41:0] dtrial;
  assign dtrial = {drem, num[16 - dstep]} - {14'd0, dvr};

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        cur <= q_head;
        phase <= 2'd0;
      end
      BK_READ: begin
        phase <= phase + 2'd1;
        if (phase == 2'd1) begin
          pa <= cur.out_a ? 72'd0 : rd_data;
        end
        if (phase == 2'd3) begin
          for (int k = 0; k < 3; k++) begin
            d[k] <= DiffW'(signed'(pa[72-24*k-1 -: 24]))
                    - DiffW'(signed'(cur.out_b ? 24'd0 : rd_data[72-24*k-1 -: 24]));
          end
          started <= 1'b0;
          rstep <= 5'd0;
        end
      end
      BK_ROOT: begin
        if (!started) begin
          for (int k = 0; k < 3; k++) begin
            mag[k] <= d[k][DiffW-1] ? 24'(-d[k]) : d[k][DiffW-2:0];
          end
          started <= 1'b1;
          rstep <= 5'd0;
          rem <= '0;
          root <= '0;
          sq <= '0;
        end else if (rstep == 5'd0 && sq == '0 && root == '0 && rem == '0
                     && !phase[0]) begin
          sq <= SqW'(mag[0] * mag[0]) + SqW'(mag[1] * mag[1])
                + SqW'(mag[2] * mag[2]);
          phase[0] <= 1'b1;
        end else if (rstep < 5'd25) begin
          rem <= trial[SqW-1] ? rem_sh : trial;
          root <= {root[RootW-2:0], !trial[SqW-1]};
          rstep <= rstep + 5'd1;
        end else begin
          len <= (rem > SqW'(root)) ? LenW'(root) + 26'd1 : LenW'(root);
          axis <= 2'd0;
          dstep <= 5'd0;
          drem <= 41'(mag[0][23:1]);
          quo <= '0;
          num <= 41'(mag[0]) << 16;
          dvr <= (rem > SqW'(root)) ? 28'(root) + 28'd1 : 28'(root);
          for (int k = 0; k < 3; k++) g[k] <= '0;
        end
      end
      BK_DIV: begin
        if (dstep < 5'd17) begin
          drem <= dtrial[41] ? {drem[39:0], num[16 - dstep]} : dtrial[40:0];
          quo <= {quo[15:0], !dtrial[41]};
          dstep <= dstep + 5'd1;
        end else begin
          // quo = floor(mag*2^16/len); round half: (q+1)/2.
          logic [16:0] q;
          logic [15:0] sat;
          q = (quo + 17'd1) >> 1;
          if (d[axis][DiffW-1]) begin
            sat = (q > 17'd32768) ? 16'h8000 : 16'(-q);
          end else begin
            sat = (q > 17'd32767) ? 16'h7FFF : q[15:0];
          end
          g[axis] <= sat;
          axis <= axis + 2'd1;
          dstep <= 5'd0;
          drem <= 41'(mag[(axis == 2'd0) ? 1 : 2][23:1]);
          quo <= '0;
          num <= 41'(mag[(axis == 2'd0) ? 1 : 2]) << 16;
        end
      end
      default: ;
    endcase
  end

  // Result register, shown for one cycle.
  logic done;
  assign done = (state == BK_ROOT && rstep == 5'd25 && sq == '0)
             || (state == BK_DIV && axis == 2'd2 && dstep == 5'd17);

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= done;
    end
  end

  logic [15:0] gz_fin;
  logic [16:0] qz;
  assign qz = (quo + 17'd1) >> 1;
  assign gz_fin = d[2][DiffW-1] ? ((qz > 17'd32768) ? 16'h8000 : 16'(-qz))
                                : ((qz > 17'd32767) ? 16'h7FFF : qz[15:0]);

  always_ff @(posedge clk) begin
    if (done) begin
      degenerate <= (sq == '0);
      constraint_value <= (sq == '0) ? -26'(cur.rest) : len - 26'(cur.rest);
      grad_x <= (sq == '0) ? 16'd0 : g[0];
      grad_y <= (sq == '0) ? 16'd0 : g[1];
      grad_z <= (sq == '0) ? 16'd0 : gz_fin;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == BK_READ) else $error("pop outside idle");
  a_strobe_pulse: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("strobe longer than a cycle");
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && degenerate) |-> grad_x == 16'd0 && grad_y == 16'd0 && grad_z == 16'd0)
    else $error("degenerate gradient");

endmodule

// ----- design/edge_distance_constraint.sv -----
// Edge distance constraint unit. Position writes (action 0) go straight into
// the position store and produce no result. An edge item (action 1) is
// classified and queued; the back end takes it from the queue, reads both
// endpoints from the position RAM, then runs a bit-serial square root and
// three bit-serial divisions, which are skipped when the endpoints coincide.
// The back end takes the next queued edge only once the previous one has
// finished. Up to QueueDepth edges wait in the queue, and busy rises when it is
// full. A position write is also held off while an edge is queued or reading
// its endpoints, so every edge sees the store as it stood when the edge was
// accepted. Results cannot be stalled; take them on the cycle that strobe is
// high. Reading a position never written is undefined.
module edge_distance_constraint import edc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [11:0] point_index,
  input  logic [23:0] pos_x,
  input  logic [23:0] pos_y,
  input  logic [23:0] pos_z,
  input  logic [11:0] first_index,
  input  logic [11:0] second_index,
  input  logic [23:0] rest_length,
  output logic        strobe,
  output logic [25:0] constraint_value,
  output logic [15:0] grad_x,
  output logic [15:0] grad_y,
  output logic [15:0] grad_z,
  output logic        degenerate
);

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  logic [71:0]      rd_data;
  logic             q_valid;
  logic             pop;
  logic             fetching;
  edge_item_t       q_head;

  edc_front u_front (
    .clk, .rst, .start, .action, .point_index, .first_index, .second_index,
    .rest_length, .pop, .fetching, .busy, .wr_en, .wr_addr, .q_valid, .q_head
  );

  edc_ram #(.Width(72), .Depth(PointCount)) u_store (
    .clk, .wr_en, .wr_addr, .wr_data({pos_x, pos_y, pos_z}), .rd_addr, .rd_data
  );

  edc_back u_back (
    .clk, .rst, .q_valid, .q_head, .rd_data, .pop, .fetching, .rd_addr, .strobe,
    .constraint_value, .grad_x, .grad_y, .grad_z, .degenerate
  );

endmodule

// ----- bench/edge_distance_constraint_test.sv -----
module edge_distance_constraint_test;
  import edc_pkg::*;

  // One edge answer as it leaves the block.
  typedef struct packed {
    logic [25:0] cval;
    logic [15:0] gx;
    logic [15:0] gy;
    logic [15:0] gz;
    logic        degen;
  } edge_answer_t;

  // Keeps its own copy of the position store and the answers still owed.
  class edge_scoreboard;
    logic signed [23:0] coord [PointCount][3];
    edge_answer_t owed[$];
    int mismatches;

    function longint unsigned root_floor(longint unsigned s);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (s >= res + bitv) begin
          s = s - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Unit component rounded half away from zero, then saturated.
    function logic [15:0] unit_part(longint signed d, longint unsigned len);
      longint unsigned mag;
      longint unsigned q;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      q = ((mag << 15) + (len >> 1)) / len;
      if (d < 0) begin
        if (q > 32768) q = 32768;
        return 16'(-longint'(q));
      end
      if (q > 32767) q = 32767;
      return 16'(q);
    endfunction

    // Notes one accepted item; an edge item adds one owed answer.
    function void note(action_t act, logic [11:0] pidx, logic signed [23:0] x,
                       logic signed [23:0] y, logic signed [23:0] z,
                       logic [11:0] fidx, logic [11:0] sidx, logic [23:0] rest);
      longint signed d[3];
      longint unsigned sq;
      longint unsigned len;
      longint unsigned m;
      edge_answer_t ans;
      if (act == ACT_WRITE) begin
        coord[pidx][0] = x;
        coord[pidx][1] = y;
        coord[pidx][2] = z;
        return;
      end
      sq = 0;
      for (int k = 0; k < 3; k++) begin
        d[k] = longint'(coord[fidx][k]) - longint'(coord[sidx][k]);
        m = (d[k] < 0) ? longint'(-d[k]) : longint'(d[k]);
        sq += m * m;
      end
      ans = '0;
      len = 0;
      if (sq == 0) begin
        ans.degen = 1'b1;
      end else begin
        len = root_floor(sq);
        if (sq - len * len > len) len = len + 1;
        ans.gx = unit_part(d[0], len);
        ans.gy = unit_part(d[1], len);
        ans.gz = unit_part(d[2], len);
      end
      ans.cval = 26'(longint'(len) - longint'(rest));
      owed.push_back(ans);
    endfunction

    function void check(edge_answer_t got);
      edge_answer_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
        return;
      end
      want = owed.pop_front();
      if (got.cval !== want.cval || got.gx !== want.gx || got.gy !== want.gy ||
          got.gz !== want.gz || got.degen !== want.degen) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected value %h grad %h %h %h degen %b, got %h %h %h %h %b",
                   want.cval, want.gx, want.gy, want.gz, want.degen,
                   got.cval, got.gx, got.gy, got.gz, got.degen);
      end
    endfunction
  endclass

  localparam int CycleLimit = 600000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        action = ACT_WRITE;
  logic [11:0] point_index = '0;
  logic [23:0] pos_x = '0;
  logic [23:0] pos_y = '0;
  logic [23:0] pos_z = '0;
  logic [11:0] first_index = '0;
  logic [11:0] second_index = '0;
  logic [23:0] rest_length = '0;
  logic        strobe;
  logic [25:0] constraint_value;
  logic [15:0] grad_x;
  logic [15:0] grad_y;
  logic [15:0] grad_z;
  logic        degenerate;

  edge_scoreboard sb = new();
  bit sender_gaps = 1'b1;
  bit written [PointCount];
  int written_list[$];
  int cycles = 0;

  edge_distance_constraint dut (.*);

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Results are sampled mid-cycle, while the strobe is stable.
  always @(negedge clk) begin
    if (!rst && strobe)
      sb.check('{constraint_value, grad_x, grad_y, grad_z, degenerate});
  end

  // Presents one item, holds it until accepted, then notes it.
  task automatic issue(action_t act, logic [11:0] pidx, logic [23:0] x, logic [23:0] y,
                       logic [23:0] z, logic [11:0] fidx, logic [11:0] sidx,
                       logic [23:0] rest);
    bit taken;
    while (sender_gaps && $urandom_range(0, 99) < 34) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    point_index <= pidx;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    first_index <= fidx;
    second_index <= sidx;
    rest_length <= rest;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    sb.note(act, pidx, x, y, z, fidx, sidx, rest);
    if (act == ACT_WRITE && !written[pidx]) begin
      written[pidx] = 1'b1;
      written_list.push_back(pidx);
    end
  endtask

  task automatic write_point(logic [11:0] pidx, logic [23:0] x, logic [23:0] y,
                             logic [23:0] z);
    issue(ACT_WRITE, pidx, x, y, z, 12'($urandom), 12'($urandom), 24'($urandom));
  endtask

  task automatic eval_edge(logic [11:0] fidx, logic [11:0] sidx, logic [23:0] rest);
    issue(ACT_EVAL, 12'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
          fidx, sidx, rest);
  endtask

  // Mix of full-range, small, extreme and clustered coordinates.
  function automatic logic [23:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 24'($urandom);
    if (r < 6) return 24'($signed($urandom_range(0, 2047)) - 1024);
    if (r < 8) begin
      case ($urandom_range(0, 2))
        0: return 24'h7FFFFF;
        1: return 24'h800000;
        default: return 24'h000000;
      endcase
    end
    return 24'($signed($urandom_range(0, 63)) - 32 + 32'sh10000);
  endfunction

  function automatic logic [23:0] pick_rest();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 4095));
      2: return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
      default: return 24'($urandom_range(0, 24'h1FFFFF));
    endcase
  endfunction

  initial begin
    int pick_a;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme corners, unit axis directions and coinciding endpoints.
    write_point(12'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    write_point(12'd4095, 24'h800000, 24'h800000, 24'h800000);
    write_point(12'd1, 24'h000000, 24'h000000, 24'h000000);
    write_point(12'd2, 24'h010000, 24'h000000, 24'h000000);
    write_point(12'd4, 24'h000000, 24'hFF0000, 24'h000000);
    write_point(12'd5, 24'h000000, 24'h000000, 24'h000003);
    eval_edge(12'd0, 12'd4095, 24'h000000);
    eval_edge(12'd4095, 12'd0, 24'hFFFFFF);
    eval_edge(12'd0, 12'd0, 24'hFFFFFF);
    eval_edge(12'd1, 12'd1, 24'h000000);
    eval_edge(12'd2, 12'd1, 24'h010000);
    eval_edge(12'd1, 12'd2, 24'h000000);
    eval_edge(12'd4, 12'd1, 24'h008000);
    eval_edge(12'd1, 12'd4, 24'hFFFFFF);
    eval_edge(12'd5, 12'd1, 24'h000001);
    eval_edge(12'd1, 12'd5, 24'h000003);
    eval_edge(12'd0, 12'd1, 24'h7FFFFF);

    // Random writes and edges; one stretch runs without gaps.
    for (int i = 0; i < 1200; i++) begin
      sender_gaps = !(i >= 400 && i < 600);
      if (i == 800) begin
        // Let the block drain completely before going on.
        start <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
      end
      if ($urandom_range(0, 99) < 45) begin
        write_point(12'($urandom), pick_coord(), pick_coord(), pick_coord());
      end else begin
        pick_a = written_list[$urandom_range(0, written_list.size() - 1)];
        if ($urandom_range(0, 9) == 0)
          eval_edge(12'(pick_a), 12'(pick_a), pick_rest());
        else
          eval_edge(12'(pick_a),
                    12'(written_list[$urandom_range(0, written_list.size() - 1)]),
                    pick_rest());
      end
    end
    start <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- edge_distance_constraint.f -----
design/edc_pkg.sv
design/edc_ram.sv
design/edc_front.sv
design/edc_back.sv
design/edge_distance_constraint.sv
bench/edge_distance_constraint_test.sv
